@@ sv/afr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg: analyser frame receiver shared types and constants
// Transaction payloads, request and status codes, frame layout positions
// and the ASCII hex helpers used by the frame assembler.
// ----------------------------------------------------------------------------
package afr_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic       chunk_end;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] duty_value;
        logic [3:0]  fail_count;
    } result_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] duty;
    } verdict_t;

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_SENT_OK = 2'd1;
    localparam logic [1:0] REQ_WR_TMO  = 2'd2;
    localparam logic [1:0] REQ_RD_TMO  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_RESET   = 2'd3;

    localparam logic CFG_MAX_CHECKSUM = 1'b0;
    localparam logic CFG_MAX_TIMEOUTS = 1'b1;

    localparam logic [3:0] LIMIT_RESET = 4'd10;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] FRAME_LEN   = 5'd16;
    localparam logic [POS_W-1:0] SUM_LEN     = 5'd13;
    localparam logic [POS_W-1:0] MIN_CHUNK   = 5'd15;
    localparam logic [POS_W-1:0] DIGIT_FIRST = 5'd8;
    localparam logic [POS_W-1:0] DIGIT_LAST  = 5'd11;
    localparam logic [POS_W-1:0] CHK_HI_POS  = 5'd13;
    localparam logic [POS_W-1:0] CHK_LO_POS  = 5'd14;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        else
            r = 5'd0;
        return r;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        r = (nib < 4'd10) ? 8'h30 + {4'b0, nib} : 8'h37 + {4'b0, nib};
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/afr_frame_asm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afr_frame_asm: reply frame assembler
// Absorbs reply bytes, keeps the running checksum, the duty digits and the
// check characters, and judges the frame on the byte that ends a chunk.
// ----------------------------------------------------------------------------
module afr_frame_asm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_en,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             chunk_end,
    output afr_pkg::verdict_t     verdict
);
    import afr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_adv;
    logic [7:0]       sum_reg, sum_next, sum_adv;
    logic [15:0]      digit_reg, digit_next, digit_adv;
    logic             stop_reg, stop_next, stop_adv;
    logic [7:0]       hi_reg, hi_next, hi_adv;
    logic [7:0]       lo_reg, lo_next, lo_adv;
    logic [4:0]       hex;

    always_comb
    begin
        hex       = hex_decode(rx_byte);
        pos_adv   = (pos_reg < FRAME_LEN) ? pos_reg + 5'd1 : pos_reg;
        sum_adv   = (pos_reg < SUM_LEN) ? sum_reg + rx_byte : sum_reg;
        digit_adv = digit_reg;
        stop_adv  = stop_reg;
        if (pos_reg >= DIGIT_FIRST && pos_reg <= DIGIT_LAST && !stop_reg)
        begin
            if (hex[4])
                digit_adv = {digit_reg[11:0], hex[3:0]};
            else
                stop_adv = 1'b1;
        end
        hi_adv = (pos_reg == CHK_HI_POS) ? rx_byte : hi_reg;
        lo_adv = (pos_reg == CHK_LO_POS) ? rx_byte : lo_reg;

        verdict.ok   = (pos_adv >= MIN_CHUNK)
                    && (to_upper(hi_adv) == hex_char(sum_adv[7:4]))
                    && (to_upper(lo_adv) == hex_char(sum_adv[3:0]));
        verdict.duty = digit_adv;

        pos_next   = pos_reg;
        sum_next   = sum_reg;
        digit_next = digit_reg;
        stop_next  = stop_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (byte_en)
        begin
            if (chunk_end)
            begin
                pos_next   = '0;
                sum_next   = '0;
                digit_next = '0;
                stop_next  = 1'b0;
                hi_next    = '0;
                lo_next    = '0;
            end
            else
            begin
                pos_next   = pos_adv;
                sum_next   = sum_adv;
                digit_next = digit_adv;
                stop_next  = stop_adv;
                hi_next    = hi_adv;
                lo_next    = lo_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            digit_reg <= '0;
            stop_reg  <= 1'b0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            digit_reg <= digit_next;
            stop_reg  <= stop_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/analyzer_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// analyzer_frame_receiver: ASCII reply frame receiver with failure runs
// Results: registered in the output register, or in the skid if that is held.
// Throughput: one item per cycle; a two-entry output stage (register plus
// skid) stalls the input only when both entries hold undelivered results.
// Reset: frame state, run counters and output stage clear; limits load 10.
// ----------------------------------------------------------------------------
`default_nettype none
module analyzer_frame_receiver (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire afr_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output afr_pkg::result_t       result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [3:0]        cfg_data
);
    import afr_pkg::*;

    logic [3:0] max_cks_reg, max_tmo_reg;
    logic [3:0] cfr_reg, cfr_next;
    logic [3:0] wto_reg, wto_next;
    logic [3:0] rto_reg, rto_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    skid_data_reg, skid_data_next;

    logic       accept, produce, out_take, byte_en, bump_en;
    logic [3:0] bump_run, bump_limit;
    logic [4:0] bump_n;
    logic       bump_over;
    logic [1:0] bump_normal;
    result_t    res;
    verdict_t   verdict;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign out_take     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign cfg_ready    = 1'b1;
    assign byte_en      = accept && (item.req_type == REQ_BYTE);

    afr_frame_asm u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .rx_byte   (item.rx_byte),
        .chunk_end (item.chunk_end),
        .verdict   (verdict)
    );

    always_comb
    begin
        bump_en     = 1'b0;
        bump_run    = cfr_reg;
        bump_limit  = max_cks_reg;
        bump_normal = ST_BAD;
        produce     = 1'b0;
        res         = '0;
        cfr_next    = cfr_reg;
        wto_next    = wto_reg;
        rto_next    = rto_reg;

        if (accept)
        begin
            unique case (item.req_type)
                REQ_SENT_OK:
                begin
                    wto_next = '0;
                end
                REQ_WR_TMO:
                begin
                    bump_en     = 1'b1;
                    bump_run    = wto_reg;
                    bump_limit  = max_tmo_reg;
                    bump_normal = ST_TIMEOUT;
                end
                REQ_RD_TMO:
                begin
                    bump_en     = 1'b1;
                    bump_run    = rto_reg;
                    bump_limit  = max_tmo_reg;
                    bump_normal = ST_TIMEOUT;
                end
                default:
                begin
                    rto_next = '0;
                    if (item.chunk_end)
                    begin
                        if (verdict.ok)
                        begin
                            produce        = 1'b1;
                            cfr_next       = '0;
                            res.status     = ST_OK;
                            res.duty_value = verdict.duty;
                        end
                        else
                        begin
                            bump_en = 1'b1;
                        end
                    end
                end
            endcase
        end

        bump_n    = {1'b0, bump_run} + 5'd1;
        bump_over = bump_n > {1'b0, bump_limit};
        if (bump_en)
        begin
            produce        = 1'b1;
            res.fail_count = bump_n[4] ? 4'd15 : bump_n[3:0];
            if (bump_over)
            begin
                res.status = ST_RESET;
                cfr_next   = '0;
                wto_next   = '0;
                rto_next   = '0;
            end
            else
            begin
                res.status = bump_normal;
                unique case (item.req_type)
                    REQ_WR_TMO: wto_next = bump_n[3:0];
                    REQ_RD_TMO: rto_next = bump_n[3:0];
                    default:    cfr_next = bump_n[3:0];
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cks_reg    <= LIMIT_RESET;
            max_tmo_reg    <= LIMIT_RESET;
            cfr_reg        <= '0;
            wto_reg        <= '0;
            rto_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_CHECKSUM: max_cks_reg <= cfg_data;
                    CFG_MAX_TIMEOUTS: max_tmo_reg <= cfg_data;
                    default:          max_tmo_reg <= max_tmo_reg;
                endcase
            end
            cfr_reg        <= cfr_next;
            wto_reg        <= wto_next;
            rto_reg        <= rto_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && skid_valid_reg))
        else $error("input stalled with free output space");

    a_reset_clears_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && res.status == ST_RESET && !skid_valid_reg)
        |=> (cfr_reg == 4'd0 && wto_reg == 4'd0 && rto_reg == 4'd0))
        else $error("run counters not cleared after reset request");

    a_sent_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.req_type == REQ_SENT_OK) |=> (wto_reg == 4'd0))
        else $error("write timeout run not cleared");

    a_runs_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (bump_en && !bump_over && item.req_type == REQ_WR_TMO)
        |=> (wto_reg == $past(bump_n[3:0])))
        else $error("run stored beyond its limit");

endmodule
`default_nettype wire
